// File: rtl/vrd_pkg.sv
package vrd_pkg;

  localparam int CW   = 16;        // component width
  localparam int FB   = 8;         // fraction bits
  localparam int VW   = 3 * CW;    // packed vector width
  localparam int SW   = 2 * CW;    // sum of squares
  localparam int RMW  = CW + 4;    // square root remainder
  localparam int QW   = FB + 1;    // unit magnitude, up to 1.0
  localparam int UW   = FB + 2;    // signed unit component
  localparam int DW   = CW + FB + 2; // rounded divide dividend
  localparam int AXIS_LAT = CW + QW + 4;

  localparam int CSW  = 15;        // cruise speed
  localparam int GW   = 16;        // gain and damping
  localparam int HW   = 16;        // raw urgency
  localparam int RVW  = 32;        // revision
  localparam int URW  = FB + 1;    // clamped urgency
  localparam int CFG_IW = 8;
  localparam int CFG_DW = 32;
  localparam int SATW = 48;

  localparam logic [CFG_IW-1:0] REG_GOAL_MODE       = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_CRUISE_SPEED    = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] REG_VELOCITY_GAIN   = CFG_IW'(2);
  localparam logic [CFG_IW-1:0] REG_ANGULAR_DAMPING = CFG_IW'(3);
  localparam logic [CFG_IW-1:0] REG_HAZARD_URGENCY  = CFG_IW'(4);
  localparam logic [CFG_IW-1:0] REG_EMERGENCY_FLAG  = CFG_IW'(5);
  localparam logic [CFG_IW-1:0] REG_GOAL_REVISION   = CFG_IW'(6);

  typedef logic signed [CW-1:0] comp_t;
  typedef logic [2:0][UW-1:0] uvec_t;

  localparam logic [UW-1:0] U_ONE  = UW'(1 << FB);
  localparam logic [UW-1:0] U_ZERO = '0;
  localparam logic [UW-1:0] U_MONE = UW'(-(1 << FB));

  // element 0 is x
  localparam uvec_t FALLBACK_FWD   = {U_MONE, U_ZERO, U_ZERO};
  localparam uvec_t FALLBACK_RIGHT = {U_ZERO, U_ZERO, U_ONE};
  localparam uvec_t FALLBACK_UP    = {U_ZERO, U_ONE, U_ZERO};

  typedef struct packed {
    logic [VW-1:0] velocity_vec;
    logic [VW-1:0] forward_vec;
    logic [VW-1:0] right_vec;
    logic [VW-1:0] up_vec;
    comp_t         pitch_rate;
    comp_t         yaw_rate;
    comp_t         roll_rate;
  } item_t;

  typedef struct packed {
    comp_t          linear_x;
    comp_t          linear_y;
    comp_t          linear_z;
    comp_t          angular_x;
    comp_t          angular_y;
    comp_t          angular_z;
    logic [URW-1:0] urgency_out;
    logic           emergency_out;
    logic [RVW-1:0] revision_out;
  } result_t;

  function automatic comp_t sat(input logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] hi;
    logic signed [SATW-1:0] lo;
    hi = SATW'((1 << (CW - 1)) - 1);
    lo = -hi - SATW'(1);
    if (v > hi) return comp_t'(hi);
    if (v < lo) return comp_t'(lo);
    return comp_t'(v);
  endfunction

endpackage

// File: rtl/vrd_unit_axis.sv
// Normalizes one axis: squares, sum, one root bit per stage, one quotient
// bit per stage, then sign and zero-length fallback.
module vrd_unit_axis (
  input  logic                  clk,
  input  logic [vrd_pkg::VW-1:0] axis,
  input  vrd_pkg::uvec_t        fallback,
  output vrd_pkg::uvec_t        unit
);
  import vrd_pkg::*;

  typedef struct packed {
    logic [2:0][CW-1:0] mag;
    logic [2:0]         neg;
    logic               zero;
  } side_t;

  logic [2:0][CW-1:0] in_mag;
  logic [2:0][CW-1:0] a_mag;
  logic [2:0]         a_neg;
  logic [2:0][SW-1:0] a_sq;
  logic [SW-1:0]      s_sum;

  side_t          sd      [0:CW];
  logic [SW-1:0]  sq_s    [0:CW];
  logic [RMW-1:0] sq_rem  [0:CW];
  logic [CW-1:0]  sq_root [0:CW];

  logic [2:0][DW-1:0] dv_rem  [0:QW];
  logic [2:0][QW-1:0] dv_q    [0:QW];
  logic [CW:0]        dv_dvs  [0:QW];
  logic [2:0]         dv_neg  [0:QW];
  logic               dv_zero [0:QW];

  uvec_t unit_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_mag[i] = axis[i*CW + CW - 1] ? CW'(~axis[i*CW +: CW] + 1'b1) : axis[i*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a_mag[i] <= in_mag[i];
      a_neg[i] <= axis[i*CW + CW - 1];
      a_sq[i]  <= SW'(in_mag[i]) * SW'(in_mag[i]);
    end
  end

  assign s_sum = a_sq[0] + a_sq[1] + a_sq[2];

  always_ff @(posedge clk) begin
    sq_s[0]    <= s_sum;
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sd[0].mag  <= a_mag;
    sd[0].neg  <= a_neg;
    sd[0].zero <= (s_sum == '0);
  end

  // digit-by-digit square root, two radicand bits per stage
  for (genvar k = 0; k < CW; k++) begin : g_sqrt
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    always_comb begin
      rem_sh = {sq_rem[k][RMW-3:0], sq_s[k][SW-1-2*k -: 2]};
      trial  = RMW'({sq_root[k], 2'b01});
    end
    always_ff @(posedge clk) begin
      sq_s[k+1] <= sq_s[k];
      sd[k+1]   <= sd[k];
      if (rem_sh >= trial) begin
        sq_rem[k+1]  <= rem_sh - trial;
        sq_root[k+1] <= {sq_root[k][CW-2:0], 1'b1};
      end else begin
        sq_rem[k+1]  <= rem_sh;
        sq_root[k+1] <= {sq_root[k][CW-2:0], 1'b0};
      end
    end
  end

  // rounded divide: (2*num + len) / (2*len)
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= DW'({sd[CW].mag[i], {(FB + 1){1'b0}}}) + DW'(sq_root[CW]);
      dv_q[0][i]   <= '0;
    end
    dv_dvs[0]  <= {sq_root[CW], 1'b0};
    dv_neg[0]  <= sd[CW].neg;
    dv_zero[0] <= sd[CW].zero;
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DW-1:0] dsh;
    assign dsh = DW'(dv_dvs[j]) << (QW - 1 - j);
    always_ff @(posedge clk) begin
      dv_dvs[j+1]  <= dv_dvs[j];
      dv_neg[j+1]  <= dv_neg[j];
      dv_zero[j+1] <= dv_zero[j];
      for (int i = 0; i < 3; i++) begin
        if (dv_rem[j][i] >= dsh) begin
          dv_rem[j+1][i] <= dv_rem[j][i] - dsh;
          dv_q[j+1][i]   <= dv_q[j][i] | (QW'(1) << (QW - 1 - j));
        end else begin
          dv_rem[j+1][i] <= dv_rem[j][i];
          dv_q[j+1][i]   <= dv_q[j][i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero[QW]) begin
        unit_next[i] = fallback[i];
      end else if (dv_neg[QW][i]) begin
        unit_next[i] = UW'(-UW'(dv_q[QW][i]));
      end else begin
        unit_next[i] = UW'(dv_q[QW][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    unit <= unit_next;
  end

endmodule

// File: rtl/velocity_and_rate_damping_demand.sv
// Velocity and rate damping demand.
// Command channel: a word is taken on a clock edge with start high and busy
// low. busy is always low, so a new word may be issued every cycle.
// Each word yields exactly one result word on result, marked by done for
// one cycle; the receiver cannot hold it off and none is needed.
// The path from start to done is one input register, the axis normalizer
// (squares, sum, one square root bit per stage, one quotient bit per stage,
// fallback), then five stages of multiply, round, sum and saturate.
// Throughput is one word per cycle.
// Configuration: write channel cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write only while no word is in
// flight. Unknown indexes are dropped.
// Reset (rst, synchronous) clears the configuration registers and the valid
// flags to zero and empties the pipeline; words in flight are lost.
module velocity_and_rate_damping_demand (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  vrd_pkg::item_t            item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [vrd_pkg::CFG_IW-1:0] cfg_index,
  input  logic [vrd_pkg::CFG_DW-1:0] cfg_data,
  output logic                      done,
  output vrd_pkg::result_t          result
);
  import vrd_pkg::*;

  localparam int MW1  = QW + CW;
  localparam int MW2  = MW1 + GW;
  localparam int TW   = MW2 - 2 * FB + 1;
  localparam int ASW  = TW + 2;
  localparam int DMW  = QW + CSW;
  localparam int DSW  = CW + 2;
  localparam int LMW  = DSW - 1 + GW;
  localparam int LW   = LMW - FB + 2;

  typedef struct packed {
    logic [VW-1:0] vel;
    comp_t         pitch;
    comp_t         yaw;
    comp_t         roll;
  } side_t;

  // configuration registers
  logic           goal_mode;
  logic [CSW-1:0] cruise_speed;
  logic [GW-1:0]  velocity_gain;
  logic [GW-1:0]  angular_damping;
  logic [HW-1:0]  hazard_urgency;
  logic           emergency_flag;
  logic [RVW-1:0] goal_revision;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_mode       <= '0;
      cruise_speed    <= '0;
      velocity_gain   <= '0;
      angular_damping <= '0;
      hazard_urgency  <= '0;
      emergency_flag  <= '0;
      goal_revision   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GOAL_MODE:       goal_mode       <= cfg_data[0];
        REG_CRUISE_SPEED:    cruise_speed    <= cfg_data[CSW-1:0];
        REG_VELOCITY_GAIN:   velocity_gain   <= cfg_data[GW-1:0];
        REG_ANGULAR_DAMPING: angular_damping <= cfg_data[GW-1:0];
        REG_HAZARD_URGENCY:  hazard_urgency  <= cfg_data[HW-1:0];
        REG_EMERGENCY_FLAG:  emergency_flag  <= cfg_data[0];
        REG_GOAL_REVISION:   goal_revision   <= cfg_data[RVW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic  v0;
  item_t it0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    it0 <= item;
  end

  uvec_t u_fwd, u_right, u_up;

  vrd_unit_axis u_axis_fwd (
    .clk      (clk),
    .axis     (it0.forward_vec),
    .fallback (FALLBACK_FWD),
    .unit     (u_fwd)
  );

  vrd_unit_axis u_axis_right (
    .clk      (clk),
    .axis     (it0.right_vec),
    .fallback (FALLBACK_RIGHT),
    .unit     (u_right)
  );

  vrd_unit_axis u_axis_up (
    .clk      (clk),
    .axis     (it0.up_vec),
    .fallback (FALLBACK_UP),
    .unit     (u_up)
  );

  // velocity and rates wait alongside the normalizers
  side_t               dl [0:AXIS_LAT-1];
  logic [AXIS_LAT-1:0] vline;

  always_ff @(posedge clk) begin
    if (rst) begin
      vline <= '0;
    end else begin
      vline <= {vline[AXIS_LAT-2:0], v0};
    end
    dl[0] <= '{vel: it0.velocity_vec, pitch: it0.pitch_rate, yaw: it0.yaw_rate,
               roll: it0.roll_rate};
    for (int k = 1; k < AXIS_LAT; k++) begin
      dl[k] <= dl[k-1];
    end
  end

  side_t sdq;
  assign sdq = dl[AXIS_LAT-1];

  // P1: unit * speed, unit * rate
  logic [2:0][QW-1:0] fmag, rmag, umag;
  logic [2:0][CW-1:0] ratemag;
  logic [2:0]         rateneg;

  logic                    p1_v;
  logic [2:0][DMW-1:0]     p1_dm;
  logic [2:0]              p1_dneg;
  logic [2:0][2:0][MW1-1:0] p1_tm;
  logic [2:0][2:0]         p1_tneg;
  logic [VW-1:0]           p1_vel;

  always_comb begin
    rateneg[0] = sdq.pitch[CW-1];
    rateneg[1] = sdq.yaw[CW-1];
    rateneg[2] = sdq.roll[CW-1];
    ratemag[0] = rateneg[0] ? CW'(-sdq.pitch) : CW'(sdq.pitch);
    ratemag[1] = rateneg[1] ? CW'(-sdq.yaw) : CW'(sdq.yaw);
    ratemag[2] = rateneg[2] ? CW'(-sdq.roll) : CW'(sdq.roll);
    for (int i = 0; i < 3; i++) begin
      fmag[i] = u_fwd[i][UW-1] ? QW'(-u_fwd[i]) : QW'(u_fwd[i]);
      rmag[i] = u_right[i][UW-1] ? QW'(-u_right[i]) : QW'(u_right[i]);
      umag[i] = u_up[i][UW-1] ? QW'(-u_up[i]) : QW'(u_up[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
    end else begin
      p1_v <= vline[AXIS_LAT-1];
    end
    p1_vel <= sdq.vel;
    for (int i = 0; i < 3; i++) begin
      p1_dm[i]      <= DMW'(fmag[i]) * DMW'(cruise_speed);
      p1_dneg[i]    <= u_fwd[i][UW-1];
      // terms: right*pitch, up*yaw, forward*roll; negative when signs agree
      p1_tm[i][0]   <= MW1'(rmag[i]) * MW1'(ratemag[0]);
      p1_tm[i][1]   <= MW1'(umag[i]) * MW1'(ratemag[1]);
      p1_tm[i][2]   <= MW1'(fmag[i]) * MW1'(ratemag[2]);
      p1_tneg[i][0] <= u_right[i][UW-1] == rateneg[0];
      p1_tneg[i][1] <= u_up[i][UW-1] == rateneg[1];
      p1_tneg[i][2] <= u_fwd[i][UW-1] == rateneg[2];
    end
  end

  // P2: round desired, scale terms by damping
  logic [2:0][DMW:0]         d_rnd;
  logic                      p2_v;
  logic signed [DSW-1:0]     p2_des [0:2];
  logic [2:0][2:0][MW2-1:0]  p2_tm;
  logic [2:0][2:0]           p2_tneg;
  logic [VW-1:0]             p2_vel;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_rnd[i] = (DMW'(p1_dm[i]) + (DMW+1)'(1 << (FB - 1))) >> FB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
    end else begin
      p2_v <= p1_v;
    end
    p2_vel  <= p1_vel;
    p2_tneg <= p1_tneg;
    for (int i = 0; i < 3; i++) begin
      if (!goal_mode) begin
        p2_des[i] <= '0;
      end else if (p1_dneg[i]) begin
        p2_des[i] <= DSW'(-DSW'(d_rnd[i]));
      end else begin
        p2_des[i] <= DSW'(d_rnd[i]);
      end
      for (int t = 0; t < 3; t++) begin
        p2_tm[i][t] <= MW2'(p1_tm[i][t]) * MW2'(angular_damping);
      end
    end
  end

  // P3: velocity error, rounded damping terms
  logic [2:0][2:0][TW-1:0] t_rnd;
  comp_t                   velc [0:2];
  logic                    p3_v;
  logic signed [DSW-1:0]   p3_diff [0:2];
  logic signed [TW-1:0]    p3_term [0:2][0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      velc[i] = $signed(p2_vel[i*CW +: CW]);
      for (int t = 0; t < 3; t++) begin
        t_rnd[i][t] = TW'((p2_tm[i][t] + MW2'(1 << (2 * FB - 1))) >> (2 * FB));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_v <= 1'b0;
    end else begin
      p3_v <= p2_v;
    end
    for (int i = 0; i < 3; i++) begin
      p3_diff[i] <= p2_des[i] - DSW'(velc[i]);
      for (int t = 0; t < 3; t++) begin
        p3_term[i][t] <= p2_tneg[i][t] ? TW'(-t_rnd[i][t]) : TW'(t_rnd[i][t]);
      end
    end
  end

  // P4: linear product, angular sum and saturate
  logic [2:0][DSW-1:0]   dmag;
  logic signed [ASW-1:0] asum [0:2];
  logic                  p4_v;
  logic [2:0][LMW-1:0]   p4_lm;
  logic [2:0]            p4_lneg;
  comp_t                 p4_ang [0:2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i] = p3_diff[i][DSW-1] ? DSW'(-p3_diff[i]) : DSW'(p3_diff[i]);
      asum[i] = ASW'(p3_term[i][0]) + ASW'(p3_term[i][1]) + ASW'(p3_term[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_v <= 1'b0;
    end else begin
      p4_v <= p3_v;
    end
    for (int i = 0; i < 3; i++) begin
      p4_lm[i]   <= LMW'(dmag[i][DSW-2:0]) * LMW'(velocity_gain);
      p4_lneg[i] <= p3_diff[i][DSW-1];
      p4_ang[i]  <= sat(SATW'(asum[i]));
    end
  end

  // P5: round linear, saturate, output word
  logic [2:0][LW-1:0]   l_rnd;
  logic signed [LW-1:0] l_sgn [0:2];
  comp_t                lin [0:2];
  logic [URW-1:0]       urg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      l_rnd[i] = LW'(((LMW+1)'(p4_lm[i]) + (LMW+1)'(1 << (FB - 1))) >> FB);
      l_sgn[i] = p4_lneg[i] ? LW'(-l_rnd[i]) : LW'(l_rnd[i]);
      lin[i]   = sat(SATW'(l_sgn[i]));
    end
    urg = (hazard_urgency > HW'(1 << FB)) ? URW'(1 << FB) : URW'(hazard_urgency);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p4_v;
    end
    result.linear_x      <= lin[0];
    result.linear_y      <= lin[1];
    result.linear_z      <= lin[2];
    result.angular_x     <= p4_ang[0];
    result.angular_y     <= p4_ang[1];
    result.angular_z     <= p4_ang[2];
    result.urgency_out   <= urg;
    result.emergency_out <= emergency_flag;
    result.revision_out  <= goal_revision;
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import vrd_pkg::*;

  localparam int LATENCY = AXIS_LAT + 6;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  item_t item;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  logic done;
  result_t result;

  velocity_and_rate_damping_demand u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .result(result)
  );

  // shadow copy of the register file
  logic        m_goal_mode;
  logic [14:0] m_cruise;
  logic [15:0] m_vgain;
  logic [15:0] m_damp;
  logic [15:0] m_urgency;
  logic        m_emerg;
  logic [31:0] m_rev;

  result_t demand_q[$];
  int errors;
  int words_sent;
  int words_checked;
  int gap_pct;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic longint comp_of(logic [VW-1:0] v, int i);
    comp_t c;
    c = v[i*CW +: CW];
    return longint'(c);
  endfunction

  function automatic longint rnd_shift(longint v, int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic comp_t clamp16(longint v);
    if (v > 32767) return comp_t'(16'sh7fff);
    if (v < -32768) return comp_t'(16'sh8000);
    return comp_t'(v);
  endfunction

  // sum of three squares stays below 2^32, so the root fits in 17 bits
  function automatic longint int_sqrt(longint s);
    longint r;
    r = 0;
    for (longint b = longint'(1) << 16; b > 0; b = b >> 1)
      if ((r + b) * (r + b) <= s) r = r + b;
    return r;
  endfunction

  // unit vector in Q.8; which selects the fallback: 0 fwd, 1 right, 2 up
  function automatic void normalize(input logic [VW-1:0] v, input int which,
                                    output longint u[3]);
    longint c[3];
    longint s;
    longint len;
    longint q;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      c[i] = comp_of(v, i);
      s += c[i] * c[i];
    end
    if (s == 0) begin
      u[0] = (which == 1) ? 256 : 0;
      u[1] = (which == 2) ? 256 : 0;
      u[2] = (which == 0) ? -256 : 0;
    end else begin
      len = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
        q = ((c[i] < 0 ? -c[i] : c[i]) << FB);
        q = (2 * q + len) / (2 * len);
        u[i] = (c[i] < 0) ? -q : q;
      end
    end
  endfunction

  function automatic longint damp_term(longint u, longint rate);
    longint m;
    m = (u < 0 ? -u : u) * (rate < 0 ? -rate : rate) * longint'(m_damp);
    m = (m + (longint'(1) << (2*FB - 1))) >>> (2*FB);
    return ((u < 0) != (rate < 0)) ? m : -m;
  endfunction

  function automatic result_t predict_demand(item_t it);
    result_t r;
    longint fw[3];
    longint rt[3];
    longint up[3];
    longint lin[3];
    longint ang[3];
    longint want;
    longint diff;
    normalize(it.forward_vec, 0, fw);
    normalize(it.right_vec, 1, rt);
    normalize(it.up_vec, 2, up);
    for (int i = 0; i < 3; i++) begin
      want = m_goal_mode ? rnd_shift(fw[i] * longint'(m_cruise), FB) : 0;
      diff = want - comp_of(it.velocity_vec, i);
      lin[i] = rnd_shift(diff * longint'(m_vgain), FB);
      ang[i] = damp_term(rt[i], longint'(it.pitch_rate))
             + damp_term(up[i], longint'(it.yaw_rate))
             + damp_term(fw[i], longint'(it.roll_rate));
    end
    r.linear_x = clamp16(lin[0]);
    r.linear_y = clamp16(lin[1]);
    r.linear_z = clamp16(lin[2]);
    r.angular_x = clamp16(ang[0]);
    r.angular_y = clamp16(ang[1]);
    r.angular_z = clamp16(ang[2]);
    r.urgency_out = (m_urgency > 256) ? URW'(256) : URW'(m_urgency);
    r.emergency_out = m_emerg;
    r.revision_out = m_rev;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && done) begin
      if (demand_q.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        exp_r = demand_q.pop_front();
        words_checked++;
        if (result.linear_x !== exp_r.linear_x) begin
          $error("linear_x exp %0d got %0d", exp_r.linear_x, result.linear_x); errors++;
        end
        if (result.linear_y !== exp_r.linear_y) begin
          $error("linear_y exp %0d got %0d", exp_r.linear_y, result.linear_y); errors++;
        end
        if (result.linear_z !== exp_r.linear_z) begin
          $error("linear_z exp %0d got %0d", exp_r.linear_z, result.linear_z); errors++;
        end
        if (result.angular_x !== exp_r.angular_x) begin
          $error("angular_x exp %0d got %0d", exp_r.angular_x, result.angular_x); errors++;
        end
        if (result.angular_y !== exp_r.angular_y) begin
          $error("angular_y exp %0d got %0d", exp_r.angular_y, result.angular_y); errors++;
        end
        if (result.angular_z !== exp_r.angular_z) begin
          $error("angular_z exp %0d got %0d", exp_r.angular_z, result.angular_z); errors++;
        end
        if (result.urgency_out !== exp_r.urgency_out) begin
          $error("urgency_out exp %0d got %0d", exp_r.urgency_out, result.urgency_out);
          errors++;
        end
        if (result.emergency_out !== exp_r.emergency_out) begin
          $error("emergency_out exp %0d got %0d", exp_r.emergency_out, result.emergency_out);
          errors++;
        end
        if (result.revision_out !== exp_r.revision_out) begin
          $error("revision_out exp %0h got %0h", exp_r.revision_out, result.revision_out);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_GOAL_MODE:       m_goal_mode = val[0];
      REG_CRUISE_SPEED:    m_cruise = val[14:0];
      REG_VELOCITY_GAIN:   m_vgain = val[15:0];
      REG_ANGULAR_DAMPING: m_damp = val[15:0];
      REG_HAZARD_URGENCY:  m_urgency = val[15:0];
      REG_EMERGENCY_FLAG:  m_emerg = val[0];
      REG_GOAL_REVISION:   m_rev = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    while (demand_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_all(input logic gm, input logic [31:0] cs, input logic [31:0] vg,
                         input logic [31:0] dmp, input logic [31:0] urg,
                         input logic em, input logic [31:0] rev);
    drain();
    write_reg(REG_GOAL_MODE, {31'b0, gm});
    write_reg(REG_CRUISE_SPEED, cs);
    write_reg(REG_VELOCITY_GAIN, vg);
    write_reg(REG_ANGULAR_DAMPING, dmp);
    write_reg(REG_HAZARD_URGENCY, urg);
    write_reg(REG_EMERGENCY_FLAG, {31'b0, em});
    write_reg(REG_GOAL_REVISION, rev);
  endtask

  // issue one word; random pre-gap from gap_pct; start stays high afterwards
  task automatic send_word(input item_t it);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    demand_q.push_back(predict_demand(it));
    words_sent++;
  endtask

  function automatic logic [VW-1:0] mk_vec(int x, int y, int z);
    return {CW'(z), CW'(y), CW'(x)};
  endfunction

  function automatic logic [15:0] rnd_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(512)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [VW-1:0] rnd_vec();
    if ($urandom_range(15) == 0) return '0;
    return {rnd_comp(), rnd_comp(), rnd_comp()};
  endfunction

  function automatic item_t rnd_item();
    item_t it;
    it.velocity_vec = rnd_vec();
    it.forward_vec = rnd_vec();
    it.right_vec = rnd_vec();
    it.up_vec = rnd_vec();
    it.pitch_rate = comp_t'(rnd_comp());
    it.yaw_rate = comp_t'(rnd_comp());
    it.roll_rate = comp_t'(rnd_comp());
    return it;
  endfunction

  task automatic test_directed();
    item_t it;
    set_all(1'b1, 32'h1234, 32'h0180, 32'h0100, 32'h0080, 1'b1, 32'hdeadbeef);
    // zero axes fall back
    it = '0;
    send_word(it);
    it.pitch_rate = comp_t'(16'sh0100);
    it.yaw_rate = comp_t'(-16'sh0200);
    it.roll_rate = comp_t'(16'sh0300);
    send_word(it);
    // extremes on the velocity, forward, right and rate components
    it.velocity_vec = mk_vec(32767, -32768, 32767);
    it.forward_vec = mk_vec(-32768, -32768, -32768);
    it.right_vec = mk_vec(32767, 32767, 32767);
    it.up_vec = mk_vec(0, 0, 1);
    it.pitch_rate = comp_t'(16'sh7fff);
    it.yaw_rate = comp_t'(16'sh8000);
    it.roll_rate = comp_t'(16'sh8000);
    send_word(it);
    it.forward_vec = '1;
    it.right_vec = mk_vec(3, 4, 0);
    it.up_vec = mk_vec(1, 1, 1);
    send_word(it);
    // saturation with full gains; urgency above one
    set_all(1'b1, 32'hffffffff, 32'hffff, 32'hffff, 32'hffff, 1'b0, 32'hffffffff);
    send_word(it);
    it = '0;
    it.velocity_vec = mk_vec(-32768, 32767, 100);
    send_word(it);
    for (int k = 0; k < 6; k++) send_word(rnd_item());
    // hold mode, zero gains, out-of-range index is dropped
    set_all(1'b0, 32'd0, 32'd0, 32'd0, 32'd256, 1'b0, 32'd0);
    write_reg(8'd7, 32'hffffffff);
    write_reg(8'hff, 32'h1);
    send_word(it);
    for (int k = 0; k < 6; k++) send_word(rnd_item());
  endtask

  task automatic rnd_regs();
    set_all(1'($urandom), $urandom, $urandom_range(3) == 0 ? $urandom : $urandom_range(512),
            $urandom_range(3) == 0 ? $urandom : $urandom_range(512),
            $urandom_range(400), 1'($urandom), $urandom);
  endtask

  task automatic test_random(input int pct, input int n);
    gap_pct = pct;
    for (int p = 0; p < 6; p++) begin
      rnd_regs();
      for (int k = 0; k < n / 6; k++) send_word(rnd_item());
      if (p == 2) begin
        // hold off until the pipe is empty
        start <= 1'b0;
        while (demand_q.size() != 0) @(posedge clk);
      end
    end
    gap_pct = 0;
  endtask

  initial begin
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    gap_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    m_goal_mode = 0; m_cruise = 0; m_vgain = 0; m_damp = 0;
    m_urgency = 0; m_emerg = 0; m_rev = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset values apply before any write
    send_word(rnd_item());
    test_directed();
    test_random(11, 600);
    test_random(63, 600);
    test_random(0, 630);
    start <= 1'b0;
    while (demand_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    $display("Sent %0d command words, checked %0d results across random and edge",
             words_sent, words_checked);
    $display("register settings, with sender gaps of 0, 11 and 63 percent.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
